// File: hdl/fdss_pkg.sv
// Shared widths, constants, scan item type and segment decode for the 4-digit scan block.
package fdss_pkg;

	localparam int VALUE_W    = 14;
	localparam int DIGIT_W    = 4;
	localparam int SEG_W      = 7;
	localparam int NUM_DIGITS = 4;
	localparam int POS_W      = 2;
	localparam int SEL_W      = NUM_DIGITS;

	localparam logic [POS_W-1:0] POS_THOUSANDS = 2'd0;
	localparam logic [POS_W-1:0] POS_ONES      = 2'd3;

	localparam logic [VALUE_W-1:0] WRAP_VALUE = 14'd10000;
	localparam logic [SEL_W-1:0]   SEL_BLANK  = 4'hF;

	// reciprocals for exact floor division of values below 10000
	localparam logic [13:0] RECIP_1000 = 14'd8389;  // >> 23
	localparam logic [12:0] RECIP_100  = 13'd5243;  // >> 19
	localparam logic [12:0] RECIP_10   = 13'd6554;  // >> 16

	// one decoded scan: pattern and active-low select per position, thousands at index 0
	typedef struct packed {
		logic [NUM_DIGITS-1:0][SEL_W-1:0] sel_n;
		logic [NUM_DIGITS-1:0][SEG_W-1:0] seg;
	} scan_t;

	// segments a..g in bits 0..6, active high
	function automatic logic [SEG_W-1:0] seg_decode(input logic [DIGIT_W-1:0] d);
		logic [SEG_W-1:0] s;
		case (d)
			4'd0: s = 7'h3F;
			4'd1: s = 7'h06;
			4'd2: s = 7'h5B;
			4'd3: s = 7'h4F;
			4'd4: s = 7'h66;
			4'd5: s = 7'h6D;
			4'd6: s = 7'h7D;
			4'd7: s = 7'h07;
			4'd8: s = 7'h7F;
			4'd9: s = 7'h6F;
			default: s = 7'h00;
		endcase
		return s;
	endfunction

endpackage

// File: hdl/fdss_digits.sv
// Four-stage elastic pipeline: wrap, reciprocal divide, digit split, decode and blanking.
module fdss_digits (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [fdss_pkg::VALUE_W-1:0]   in_value,
	output logic                           out_valid,
	input  logic                           out_ready,
	output fdss_pkg::scan_t                out_scan
);

	logic valid_s1, valid_s2, valid_s3, valid_s4;
	logic adv1, adv2, adv3, adv4;

	logic [fdss_pkg::VALUE_W-1:0] v_s1, v_s2;
	logic [3:0]                   th_s2;
	logic [6:0]                   q100_s2;
	logic [9:0]                   q10_s2;
	logic [fdss_pkg::NUM_DIGITS-1:0][fdss_pkg::DIGIT_W-1:0] d_s3;
	fdss_pkg::scan_t              scan_s4;

	logic [27:0] prod1000;
	logic [26:0] prod100;
	logic [26:0] prod10;
	logic [6:0]  rem100;
	logic [9:0]  rem10;
	logic [13:0] rem1;
	logic [fdss_pkg::NUM_DIGITS-1:0] seen;
	fdss_pkg::scan_t scan_d;

	// a stage loads when it is empty or its contents move on
	assign adv4     = !valid_s4 || out_ready;
	assign adv3     = !valid_s3 || adv4;
	assign adv2     = !valid_s2 || adv3;
	assign adv1     = !valid_s1 || adv2;
	assign in_ready = adv1;

	assign out_valid = valid_s4;
	assign out_scan  = scan_s4;

	assign prod1000 = 28'(v_s1) * 28'(fdss_pkg::RECIP_1000);
	assign prod100  = 27'(v_s1) * 27'(fdss_pkg::RECIP_100);
	assign prod10   = 27'(v_s1) * 27'(fdss_pkg::RECIP_10);

	assign rem100 = q100_s2 - 7'(th_s2) * 7'd10;
	assign rem10  = q10_s2 - 10'(q100_s2) * 10'd10;
	assign rem1   = v_s2 - 14'(q10_s2) * 14'd10;

	always_comb begin
		for (int p = 0; p < fdss_pkg::NUM_DIGITS; p++) begin
			if (p == 0) begin
				seen[p] = (d_s3[p] != '0);
			end else begin
				seen[p] = seen[p-1] || (d_s3[p] != '0);
			end
			scan_d.seg[p]   = fdss_pkg::seg_decode(d_s3[p]);
			scan_d.sel_n[p] = seen[p] ? ~(fdss_pkg::SEL_W'(1) << p) : fdss_pkg::SEL_BLANK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
		end else begin
			if (adv1) valid_s1 <= in_valid;
			if (adv2) valid_s2 <= valid_s1;
			if (adv3) valid_s3 <= valid_s2;
			if (adv4) valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			// field tops out at 16383, one subtract wraps it
			v_s1 <= (in_value >= fdss_pkg::WRAP_VALUE) ? in_value - fdss_pkg::WRAP_VALUE
			                                           : in_value;
		end
		if (adv2) begin
			v_s2    <= v_s1;
			th_s2   <= prod1000[26:23];
			q100_s2 <= prod100[25:19];
			q10_s2  <= prod10[25:16];
		end
		if (adv3) begin
			d_s3[0] <= th_s2;
			d_s3[1] <= rem100[3:0];
			d_s3[2] <= rem10[3:0];
			d_s3[3] <= rem1[3:0];
		end
		if (adv4) begin
			scan_s4 <= scan_d;
		end
	end

endmodule

// File: hdl/four_digit_seven_segment_scan.sv
// Top level: value stream in, four digit scan beats out per value.
//
// Input stream (s_axis): one beat carries a 14-bit unsigned value; values above
// 9999 are shown modulo 10000. Output stream (m_axis): four beats per value, in
// the order thousands, hundreds, tens, ones. Each beat carries the active-high
// segment pattern (a..g) and an active-low digit select; leading zero digits get
// an all-high select, and a value of zero blanks all four positions. tuser holds
// the position, tlast marks the ones beat.
//
// An accepted value passes the four pipeline stages and then the scan output
// register before its first beat is valid. Throughput is bounded by the four beats
// per value on the single output port; the pipeline keeps taking values while the
// output register is still scanning.
// Reset clears all valid bits and the beat counter; nothing else needs clearing.
// When the receiver holds tready low the current beat stays put, the pipeline
// fills and then s_axis_tready drops; no beat is lost or repeated.
module four_digit_seven_segment_scan (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // [13:0] value, [15:14] zero
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [6:0] segments, [10:7] digit_select_n, [15:11] zero
	output logic [1:0]  m_axis_tuser,   // [1:0] position
	output logic        m_axis_tlast
);

	logic            pipe_valid;
	logic            pipe_ready;
	fdss_pkg::scan_t pipe_scan;

	fdss_pkg::scan_t                 scan_q;
	logic                            busy_q;
	logic [fdss_pkg::POS_W-1:0]      pos_q;
	logic                            out_beat;
	logic                            last_beat;

	fdss_digits u_digits (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_value  (s_axis_tdata[fdss_pkg::VALUE_W-1:0]),
		.out_valid (pipe_valid),
		.out_ready (pipe_ready),
		.out_scan  (pipe_scan)
	);

	assign out_beat   = m_axis_tvalid && m_axis_tready;
	assign last_beat  = out_beat && (pos_q == fdss_pkg::POS_ONES);
	assign pipe_ready = !busy_q || last_beat;

	assign m_axis_tvalid = busy_q;
	assign m_axis_tuser  = pos_q;
	assign m_axis_tlast  = (pos_q == fdss_pkg::POS_ONES);
	assign m_axis_tdata  = {5'b0, scan_q.sel_n[pos_q], scan_q.seg[pos_q]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= fdss_pkg::POS_THOUSANDS;
		end else begin
			if (pipe_ready) begin
				busy_q <= pipe_valid;
				pos_q  <= fdss_pkg::POS_THOUSANDS;
			end else if (out_beat) begin
				pos_q <= pos_q + 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_ready && pipe_valid) begin
			scan_q <= pipe_scan;
		end
	end

	// a scan always restarts at the thousands digit
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && m_axis_tlast |=> (m_axis_tuser == fdss_pkg::POS_THOUSANDS))
		else $error("scan did not restart at thousands");

	// a scan runs through all four positions without dropping out
	a_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_beat && !m_axis_tlast |=>
			m_axis_tvalid && (m_axis_tuser == $past(m_axis_tuser) + 2'd1))
		else $error("scan position skipped or scan ended early");

	// select is blank or pulls low only this beat's position
	a_select: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[10:7] == fdss_pkg::SEL_BLANK) ||
			(~m_axis_tdata[10:7] == (4'b0001 << m_axis_tuser)))
		else $error("bad digit select");

	// a blank ones digit means the value was zero, so the pattern is the glyph for zero
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast && (m_axis_tdata[10:7] == fdss_pkg::SEL_BLANK) |->
			(m_axis_tdata[6:0] == 7'h3F))
		else $error("blank ones digit with nonzero pattern");

endmodule

// File: sim/tb_four_digit_seven_segment_scan.sv
// Testbench for the four-digit seven-segment scan block: directed and random values in, digit beats checked.
`timescale 1ns / 100ps

import fdss_pkg::*;

typedef struct packed {
	logic [SEG_W-1:0] seg;
	logic [SEL_W-1:0] sel_n;
	logic [POS_W-1:0] pos;
	logic             last;
	logic [4:0]       pad;
} digit_beat_t;

class digit_scoreboard;
	digit_beat_t pending_digits[$];
	int unsigned mismatches;

	function new();
		mismatches = 0;
	endfunction

	function automatic logic [SEG_W-1:0] glyph(input int unsigned d);
		case (d)
			0: return 7'h3F;
			1: return 7'h06;
			2: return 7'h5B;
			3: return 7'h4F;
			4: return 7'h66;
			5: return 7'h6D;
			6: return 7'h7D;
			7: return 7'h07;
			8: return 7'h7F;
			default: return 7'h6F;
		endcase
	endfunction

	// expand one accepted value into its four digit beats, thousands first
	function automatic void note_value(input logic [VALUE_W-1:0] value);
		int unsigned shown;
		int unsigned weight;
		int unsigned d;
		bit lit;
		digit_beat_t b;
		shown = value % 10000;
		weight = 1000;
		lit = 1'b0;
		for (int p = 0; p < NUM_DIGITS; p++) begin
			d = (shown / weight) % 10;
			weight = weight / 10;
			if (d != 0)
				lit = 1'b1;
			b.seg = glyph(d);
			b.sel_n = lit ? ~(SEL_W'(1) << p) : SEL_BLANK;
			b.pos = POS_W'(p);
			b.last = (POS_W'(p) == POS_ONES);
			b.pad = '0;
			pending_digits.push_back(b);
		end
	endfunction

	function int unsigned pending();
		return pending_digits.size();
	endfunction

	task report_mismatch(input string msg);
		$display("%0t mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	task check_beat(input digit_beat_t got);
		digit_beat_t want;
		if (pending_digits.size() == 0) begin
			report_mismatch($sformatf("beat with nothing pending, pos %0d", got.pos));
			return;
		end
		want = pending_digits.pop_front();
		if (got.seg != want.seg)
			report_mismatch($sformatf("segments %h, want %h (pos %0d)",
				got.seg, want.seg, want.pos));
		if (got.sel_n != want.sel_n)
			report_mismatch($sformatf("digit_select_n %h, want %h (pos %0d)",
				got.sel_n, want.sel_n, want.pos));
		if (got.pos != want.pos)
			report_mismatch($sformatf("position %0d, want %0d", got.pos, want.pos));
		if (got.last != want.last)
			report_mismatch($sformatf("tlast %b, want %b (pos %0d)",
				got.last, want.last, want.pos));
		if (got.pad != want.pad)
			report_mismatch($sformatf("tdata pad bits %h, want zero", got.pad));
	endtask
endclass

module tb_four_digit_seven_segment_scan;

	localparam int RANDOM_VALUES = 257;
	localparam int QUIET_LIMIT   = 2000;
	localparam int DRAIN_CYCLES  = 16;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [15:0] m_axis_tdata;
	logic [1:0]  m_axis_tuser;
	logic        m_axis_tlast;

	bit steady = 1'b0;  // no idling on either side while set

	digit_scoreboard sb = new();

	four_digit_seven_segment_scan dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// receiver backpressure
	always @(posedge clk) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= steady || ($urandom_range(99) >= 30);
	end

	// beat monitor: inputs feed the prediction, outputs get checked
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_axis_tvalid && s_axis_tready)
				sb.note_value(s_axis_tdata[VALUE_W-1:0]);
			if (m_axis_tvalid && m_axis_tready)
				sb.check_beat({m_axis_tdata[SEG_W-1:0], m_axis_tdata[SEG_W+SEL_W-1:SEG_W],
					m_axis_tuser, m_axis_tlast, m_axis_tdata[15:SEG_W+SEL_W]});
		end
	end

	// ends the run if no beat moves on either side for too long
	initial begin : watchdog
		int unsigned quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("four_digit_seven_segment_scan test failed");
		$finish;
	end

	// valid stays high from one value to the next unless an idle cycle is drawn
	task automatic send_value(input logic [VALUE_W-1:0] v);
		while (!steady && $urandom_range(99) < 30) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {{(16-VALUE_W){1'b0}}, v};
		do
			@(posedge clk);
		while (!s_axis_tready);
	endtask

	function automatic logic [VALUE_W-1:0] pick_value();
		int unsigned v;
		case ($urandom_range(9))
			4: v = $urandom_range(9);
			5: v = $urandom_range(99, 10);
			6: v = $urandom_range(999, 100);
			7: v = $urandom_range(16383, 10000);
			8: v = $urandom_range(9999, 1000);
			9: begin
				// sparse digits: zeros in the middle and at the front
				v = 0;
				for (int k = 0; k < NUM_DIGITS; k++)
					v = v * 10 + ($urandom_range(1) ? $urandom_range(9) : 0);
			end
			default: v = $urandom_range(16383);
		endcase
		return VALUE_W'(v);
	endfunction

	initial begin : stimulus
		int unsigned directed[] = '{0, 1, 9, 10, 99, 100, 999, 1000, 9999, 10000, 10001,
			16383, 1234, 5678, 9012, 3456, 7890, 4321, 2008, 305, 9090, 6543, 8000};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i])
			send_value(VALUE_W'(directed[i]));

		for (int n = 0; n < RANDOM_VALUES; n++) begin
			steady <= (n >= 120 && n < 180);
			send_value(pick_value());
		end
		s_axis_tvalid <= 1'b0;
		steady <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending() == 0)
			$display("four_digit_seven_segment_scan test passed");
		else
			$display("four_digit_seven_segment_scan test failed");
		$finish;
	end

endmodule

// File: four_digit_seven_segment_scan.f
hdl/fdss_pkg.sv
hdl/fdss_digits.sv
hdl/four_digit_seven_segment_scan.sv
sim/tb_four_digit_seven_segment_scan.sv
